FILE: rtl/olde_pkg.sv
package olde_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int LEN_W     = 7;

  localparam logic [2:0] KIND_APPEND = 3'd0;
  localparam logic [2:0] KIND_DHEAD  = 3'd1;
  localparam logic [2:0] KIND_DTAIL  = 3'd2;
  localparam logic [2:0] KIND_DPOS   = 3'd3;
  localparam logic [2:0] KIND_DVAL   = 3'd4;
  localparam logic [2:0] KIND_DISP   = 3'd5;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_EMPTY    = 3'd1;
  localparam logic [2:0] STAT_BADPOS   = 3'd2;
  localparam logic [2:0] STAT_NOTFOUND = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  typedef enum logic [1:0] {M_IDX, M_VAL, M_DISP} seq_mode_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    OP_HOLD,    // keep
    OP_SHIFT,   // cells below len-1 take the right neighbor (closes a gap at the head)
    OP_ROT,     // as shift, and cell len-1 takes the head
    OP_APPEND   // cell len takes the incoming value
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [LEN_W-1:0]   len;
  } cell_cmd_t;

endpackage

FILE: rtl/olde_cell.sv
module olde_cell
  import olde_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] right_val,
  input  logic [DATA_W-1:0] head_val,
  input  logic [DATA_W-1:0] in_val,
  output logic [DATA_W-1:0] val
);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;
  logic              below_tail;
  logic              at_tail;
  logic              at_free;

  assign below_tail = LEN_W'(IDX + 1) < cmd.len;
  assign at_tail    = LEN_W'(IDX + 1) == cmd.len;
  assign at_free    = LEN_W'(IDX) == cmd.len;

  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      OP_SHIFT: begin
        if (below_tail) val_nxt = right_val;
      end
      OP_ROT: begin
        if (below_tail) val_nxt = right_val;
        else if (at_tail) val_nxt = head_val;
      end
      OP_APPEND: begin
        if (at_free) val_nxt = in_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

FILE: rtl/ordered_list_delete_engine_unit.sv
// channel | direction | fields                                      | handshake
// in      | input     | kind[2:0] value[31:0] position[7:0]         | in_valid / in_stall
// out     | output    | status[2:0] item_value[31:0] last length[6:0] | out_valid / out_stall
//
// Append and a request refused at once (full, empty, bad position) finish with no walk.
// A delete or a display walks the list after the accept, one step per entry, rotating
// the cell chain. Each step needs the output register free. Only one request is in work.
// Reset (rst_n low, synchronous) empties the list; cell contents are not cleared.
// A stalled result holds the walk; a new request is taken once the walk is over
// and the output register is empty or its beat is taken in that same cycle.
module ordered_list_delete_engine_unit
  import olde_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [7:0]               in_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_status,
  output logic signed [DATA_W-1:0] out_item_value,
  output logic                     out_last,
  output logic [LEN_W-1:0]         out_length
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] cell_val [DEPTH];
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] head;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     step_r, step_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  seq_mode_t         mode_r, mode_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic              found_r, found_nxt;
  logic [DATA_W-1:0] del_r, del_nxt;

  logic              out_valid_r;
  logic [2:0]        status_r;
  logic [DATA_W-1:0] item_r;
  logic              last_r;
  logic [LEN_W-1:0]  length_r;

  logic              out_free;
  logic              in_acc;
  logic              start;
  logic              final_step;
  logic              drop;
  logic              emit;
  logic [2:0]        em_status;
  logic [DATA_W-1:0] em_item;
  logic              em_last;
  logic [LEN_W-1:0]  em_length;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] right;
    if (i < DEPTH - 1) begin : g_mid
      assign right = cell_val[i+1];
    end else begin : g_end
      assign right = cell_val[i];
    end
    olde_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .right_val (right),
      .head_val  (cell_val[0]),
      .in_val    (in_value),
      .val       (cell_val[i])
    );
  end

  assign head       = cell_val[0];
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !(state_r == ST_IDLE && out_free);
  assign in_acc     = in_valid && !in_stall;
  assign final_step = step_r == n_r - CW'(1);
  assign drop       = !found_r && mode_r != M_DISP &&
                      ((mode_r == M_VAL && head == key_r) ||
                       (mode_r == M_IDX && step_r == idx_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && start) state_nxt = ST_RUN;
      ST_RUN:  if (out_free && final_step) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = OP_HOLD;
    cmd.len   = LEN_W'(count_r);
    start     = 1'b0;
    emit      = 1'b0;
    em_status = STAT_OK;
    em_item   = '0;
    em_last   = 1'b1;
    em_length = LEN_W'(count_r);
    count_nxt = count_r;
    n_nxt     = n_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    mode_nxt  = mode_r;
    key_nxt   = key_r;
    found_nxt = found_r;
    del_nxt   = del_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          n_nxt     = count_r;
          step_nxt  = '0;
          found_nxt = 1'b0;
          key_nxt   = in_value;
          del_nxt   = '0;
          unique case (in_kind) inside
            KIND_APPEND: begin
              emit = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                em_status = STAT_FULL;
              end else begin
                cmd.op    = OP_APPEND;
                count_nxt = count_r + CW'(1);
                em_length = LEN_W'(count_r + CW'(1));
              end
            end
            KIND_DHEAD, KIND_DTAIL: begin
              if (count_r == '0) begin
                emit      = 1'b1;
                em_status = STAT_EMPTY;
              end else begin
                start    = 1'b1;
                mode_nxt = M_IDX;
                idx_nxt  = (in_kind == KIND_DHEAD) ? '0 : count_r - CW'(1);
              end
            end
            KIND_DPOS: begin
              if (in_position == 8'd0 || 9'(in_position) > 9'(count_r)) begin
                emit      = 1'b1;
                em_status = STAT_BADPOS;
              end else begin
                start    = 1'b1;
                mode_nxt = M_IDX;
                idx_nxt  = CW'(in_position - 8'd1);
              end
            end
            KIND_DVAL, KIND_DISP: begin
              if (count_r == '0) begin
                emit      = 1'b1;
                em_status = STAT_EMPTY;
              end else begin
                start    = 1'b1;
                mode_nxt = (in_kind == KIND_DVAL) ? M_VAL : M_DISP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (out_free) begin
          step_nxt = step_r + CW'(1);
          if (drop) begin
            // head leaves the ring; the rest keeps rotating
            cmd.op    = OP_SHIFT;
            count_nxt = count_r - CW'(1);
            found_nxt = 1'b1;
            del_nxt   = head;
          end else begin
            cmd.op = OP_ROT;
          end
          if (mode_r == M_DISP) begin
            emit    = 1'b1;
            em_item = head;
            em_last = final_step;
          end else if (final_step) begin
            emit      = 1'b1;
            em_length = LEN_W'(count_nxt);
            if (drop) begin
              em_item = head;
            end else if (found_r) begin
              em_item = del_r;
            end else begin
              em_status = STAT_NOTFOUND;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    mode_r <= mode_nxt;
    key_r  <= key_nxt;
    del_r  <= del_nxt;
    if (emit) begin
      status_r <= em_status;
      item_r   <= em_item;
      last_r   <= em_last;
      length_r <= em_length;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_item_value = item_r;
  assign out_last       = last_r;
  assign out_length     = length_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> step_r < n_r)
    else $error("walk step past list length");

  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && found_r |-> count_r == n_r - CW'(1))
    else $error("length mismatch after drop");

  a_notfound_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && !found_r |-> count_r == n_r)
    else $error("length changed without drop");

  a_disp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && mode_r == M_DISP |-> !found_r)
    else $error("display dropped an entry");

endmodule

FILE: tb/list_scoreboard_pkg.sv
package list_sb_pkg;
  import olde_pkg::*;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] item_value;
    logic                     last;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  class list_scoreboard;
    int unsigned              depth;
    logic signed [DATA_W-1:0] entries[$];     // head at index 0
    list_result_t             expected_q[$];
    int unsigned              mismatches;

    function new(int unsigned depth_i);
      depth = depth_i;
      mismatches = 0;
    endfunction

    // length is taken after the list has been updated
    function void add_expected(logic [2:0] status, logic signed [DATA_W-1:0] item_value,
                               logic last);
      list_result_t r;
      r.status = status;
      r.item_value = item_value;
      r.last = last;
      r.length = LEN_W'(entries.size());
      expected_q.push_back(r);
    endfunction

    function void note_request(logic [2:0] kind, logic signed [DATA_W-1:0] value,
                               logic [7:0] position);
      logic signed [DATA_W-1:0] victim;
      int hit;
      hit = -1;
      case (kind)
        KIND_APPEND: begin
          if (entries.size() >= depth) begin
            add_expected(STAT_FULL, '0, 1'b1);
          end else begin
            entries.push_back(value);
            add_expected(STAT_OK, '0, 1'b1);
          end
        end
        KIND_DHEAD, KIND_DTAIL: begin
          if (entries.size() == 0) begin
            add_expected(STAT_EMPTY, '0, 1'b1);
          end else begin
            victim = (kind == KIND_DHEAD) ? entries.pop_front() : entries.pop_back();
            add_expected(STAT_OK, victim, 1'b1);
          end
        end
        KIND_DPOS: begin
          if (position == 0 || position > entries.size()) begin
            add_expected(STAT_BADPOS, '0, 1'b1);
          end else begin
            victim = entries[position - 1];
            entries.delete(position - 1);
            add_expected(STAT_OK, victim, 1'b1);
          end
        end
        KIND_DVAL: begin
          if (entries.size() == 0) begin
            add_expected(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < entries.size() && hit < 0; i++)
              if (entries[i] == value) hit = i;
            if (hit < 0) begin
              add_expected(STAT_NOTFOUND, '0, 1'b1);
            end else begin
              victim = entries[hit];
              entries.delete(hit);
              add_expected(STAT_OK, victim, 1'b1);
            end
          end
        end
        KIND_DISP: begin
          if (entries.size() == 0) begin
            add_expected(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < entries.size(); i++)
              add_expected(STAT_OK, entries[i], i == entries.size() - 1);
          end
        end
        default: ;  // spare kinds are dropped by the block
      endcase
    endfunction

    function void check_result(logic [2:0] status, logic signed [DATA_W-1:0] item_value,
                               logic last, logic [LEN_W-1:0] length);
      list_result_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d value %0d last %0d length %0d",
                   status, item_value, last, length);
        return;
      end
      exp = expected_q.pop_front();
      if (status !== exp.status || item_value !== exp.item_value ||
          last !== exp.last || length !== exp.length) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected status %0d value %0d last %0d length %0d, ",
                    "got status %0d value %0d last %0d length %0d"},
                   exp.status, exp.item_value, exp.last, exp.length,
                   status, item_value, last, length);
      end
    endfunction

    function void flush_check();
      if (expected_q.size() != 0) begin
        mismatches++;
        $display("%0d expected result beats never arrived", expected_q.size());
      end
    endfunction
  endclass

endpackage

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import olde_pkg::*;
  import list_sb_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int REQUESTS    = 310;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;

  // kinds the block must ignore
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               in_kind = KIND_APPEND;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [7:0]               in_position = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [2:0]               out_status;
  logic signed [DATA_W-1:0] out_item_value;
  logic                     out_last;
  logic [LEN_W-1:0]         out_length;

  list_scoreboard sb;
  int unsigned    requests_sent = 0;
  int unsigned    burst_left = 0;
  int unsigned    idle_cycles = 0;

  ordered_list_delete_engine_unit #(.DEPTH(DEPTH)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_item_value (out_item_value),
    .out_last       (out_last),
    .out_length     (out_length)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return $signed($urandom_range(0, 8)) - 4;  // small range makes duplicates
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [2:0] kind, input logic signed [DATA_W-1:0] value,
                              input logic [7:0] position);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_value    <= value;
    in_position <= position;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, value, position);
    burst_left--;
    if (kind <= KIND_DISP) requests_sent++;
  endtask

  task automatic random_request(input bit filling);
    int unsigned              cnt;
    int unsigned              roll;
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] value;
    logic [7:0]               position;
    cnt = sb.entries.size();
    value = pick_value();
    position = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      kind = $urandom_range(0, 1) ? KIND_SPARE_B : KIND_SPARE_A;
    end else if (roll < (filling ? 75 : 18)) begin
      kind = KIND_APPEND;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 15) kind = KIND_DHEAD;
      else if (roll < 30) kind = KIND_DTAIL;
      else if (roll < 55) kind = KIND_DPOS;
      else if (roll < 85) kind = KIND_DVAL;
      else kind = KIND_DISP;
    end
    roll = $urandom_range(0, 9);
    if (kind == KIND_DVAL && cnt != 0 && roll < 7)
      value = sb.entries[$urandom_range(0, cnt - 1)];
    if (kind == KIND_DPOS) begin
      if (cnt != 0 && roll < 7) position = 8'($urandom_range(1, cnt));
      else if (roll < 9) position = (roll == 8) ? 8'd0 : 8'(cnt + 1);
    end
    send_request(kind, value, position);
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_item_value, out_last, out_length);
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned cyc;
    bit          held;
    span = 0;
    cyc = 0;
    held = 0;
    forever begin
      @(posedge clk);
      // one long hold-off so the block backs up into its input
      if (!held && requests_sent >= 120) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 80);
      end
      span--;
      cyc++;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (cyc % 7) < 3;
      endcase
    end
  end

  initial begin : stimulus
    bit filling;
    sb = new(DEPTH);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: every request fails; then appends, bad positions, misses and spare kinds
    send_request(KIND_DISP, '0, 8'd0);
    send_request(KIND_DHEAD, '0, 8'd0);
    send_request(KIND_DTAIL, '0, 8'd0);
    send_request(KIND_DPOS, '0, 8'd1);
    send_request(KIND_DVAL, 32'sd5, 8'd0);
    send_request(KIND_APPEND, 32'h8000_0000, 8'd0);
    send_request(KIND_APPEND, 32'h7fff_ffff, 8'd0);
    send_request(KIND_APPEND, -32'sd1, 8'd0);
    send_request(KIND_APPEND, 32'sd0, 8'd0);
    send_request(KIND_APPEND, -32'sd1, 8'd0);
    send_request(KIND_DISP, '0, 8'd0);
    send_request(KIND_DPOS, '0, 8'd0);
    send_request(KIND_DPOS, '0, 8'd255);
    send_request(KIND_DPOS, '0, 8'd6);
    send_request(KIND_DVAL, 32'sd12345, 8'd0);
    // duplicate value: only the first match goes
    send_request(KIND_DVAL, -32'sd1, 8'd0);
    send_request(KIND_DPOS, '0, 8'd2);
    send_request(KIND_DTAIL, '0, 8'd0);
    send_request(KIND_SPARE_A, 32'hffff_ffff, 8'hff);
    send_request(KIND_SPARE_B, 32'h0, 8'h0);
    send_request(KIND_DHEAD, '0, 8'd0);
    send_request(KIND_DISP, '0, 8'd0);

    // alternate fill and drain phases so full and empty are both hit repeatedly
    filling = 1;
    while (requests_sent < REQUESTS) begin
      if (filling && sb.entries.size() >= DEPTH) begin
        filling = 0;
        send_request(KIND_APPEND, pick_value(), 8'd0);
      end else begin
        if (!filling && sb.entries.size() == 0) filling = 1;
        random_request(filling);
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
    sb.flush_check();
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
